[design/ieu_pkg.sv]
// Shared types, codes and constants of the integer execute unit.
`timescale 1ns / 1ps

package ieu_pkg;

    localparam int DATA_W        = 32;
    localparam int REG_IDX_W     = 5;
    localparam int FUNC_W        = 5;
    localparam int IMM_W         = 16;
    localparam int SHAMT_W       = 5;
    localparam int BASE_W        = 10;
    localparam int IDX_W         = 18;
    localparam int IN_TDATA_W    = 80;
    localparam int OUT_TDATA_W   = 80;
    localparam int NUM_REGS_DEF  = 32;
    localparam int MEM_WORDS_DEF = 1024;

    // Byte offsets divide by four to give word indexes.
    localparam int WORD_SHIFT    = 2;
    localparam logic [BASE_W-1:0] MEM_BASE_RESET = 10'd20;

    typedef enum logic [FUNC_W-1:0] {
        F_ADD  = 5'd0,
        F_ADDI = 5'd1,
        F_SUB  = 5'd2,
        F_MULT = 5'd3,
        F_MFHI = 5'd4,
        F_MFLO = 5'd5,
        F_AND  = 5'd6,
        F_OR   = 5'd7,
        F_NOR  = 5'd8,
        F_SLL  = 5'd9,
        F_SRL  = 5'd10,
        F_LW   = 5'd11,
        F_SW   = 5'd12,
        F_SLT  = 5'd13,
        F_BNE  = 5'd14,
        F_BEQ  = 5'd15,
        F_J    = 5'd16,
        F_NOP  = 5'd17
    } t_func;

    // Where the register write value comes from in the second stage.
    typedef enum logic [1:0] {
        WS_ALU = 2'd0,
        WS_MEM = 2'd1,
        WS_HI  = 2'd2,
        WS_LO  = 2'd3
    } t_wsrc;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } t_rf_wr;

    typedef struct packed {
        logic              wr;
        t_wsrc             wsrc;
        logic [DATA_W-1:0] val;
        logic              taken;
        logic              bad;
        logic              fault;
        logic              ld;
        logic              st;
        logic              mul;
    } t_ex;

endpackage

[design/integer_execute_unit_hilo.sv]
// Top level of the integer execute unit: pipeline control, forwarding and hi/lo.
`timescale 1ns / 1ps
//
//  Channel   Direction  Beat fields (tdata, lowest bit first)
//  --------  ---------  ---------------------------------------------------------
//  s_axis    in         func[4:0] rd[9:5] rs[14:10] rt[19:15] immediate[35:20]
//                       shamt[40:36] target[72:41], zero pad to 80 bits
//  m_axis    out        reg_written[0] written_reg[5:1] written_value[37:6]
//                       branch_taken[38] branch_target[70:39] bad_instr[71]
//                       mem_fault[72], zero pad to 80 bits
//  cfg       in         i_cfg_we / i_cfg_wdata: mem_base, 10 bits
//
//  One instruction per cycle enters while m_axis takes results; each accepted
//  beat passes register file read, then execute + data memory access, then
//  write-back into the output register, from which its result leaves.
//  Reset clears the pipeline valids, hi/lo, register file valid bits and sets
//  mem_base to 20; the data memory holds whatever it holds until written.
//  A stall on m_axis fills the output register, then the second and first
//  stage, before s_axis tready drops; a bubble anywhere lets the input move.
//  Back-to-back dependences are covered by forwarding from the second stage and
//  by the write bypass of the register file, so the pipeline has no interlock.

module integer_execute_unit_hilo #(
    parameter int MEM_WORDS = ieu_pkg::MEM_WORDS_DEF,
    parameter int NUM_REGS  = ieu_pkg::NUM_REGS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // func, rd, rs, rt, immediate, shamt, target (see table above)
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ieu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // reg_written, written_reg, written_value, branch_taken, branch_target,
    // bad_instr, mem_fault (see table above)
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ieu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [ieu_pkg::BASE_W-1:0]         i_cfg_wdata
);

    localparam int DW = ieu_pkg::DATA_W;
    localparam int RW = ieu_pkg::REG_IDX_W;
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [RW:0] NREGS = (RW+1)'(NUM_REGS);

    // Handshake and stage movement.
    logic accept, s1_move, s2_move, out_adv;

    // Configuration.
    logic [ieu_pkg::BASE_W-1:0] r_mem_base;

    // Stage 1: decoded fields; register file data arrives in this stage.
    logic                        r1_v;
    logic [ieu_pkg::FUNC_W-1:0]  r1_func;
    logic [RW-1:0]               r1_rd, r1_rs, r1_rt;
    logic [ieu_pkg::IMM_W-1:0]   r1_imm;
    logic [ieu_pkg::SHAMT_W-1:0] r1_shamt;
    logic [DW-1:0]               r1_tgt;

    // Stage 2: execute results; load data arrives in this stage.
    logic                        r2_v;
    logic                        r2_wr;
    logic [RW-1:0]               r2_rd;
    ieu_pkg::t_wsrc              r2_wsrc;
    logic [DW-1:0]               r2_val;
    logic                        r2_taken;
    logic [DW-1:0]               r2_tgt;
    logic                        r2_bad;
    logic                        r2_fault;

    // Output register.
    logic                        r_ov;
    logic                        r_o_wr;
    logic [RW-1:0]               r_o_rd;
    logic [DW-1:0]               r_o_val;
    logic                        r_o_taken;
    logic [DW-1:0]               r_o_tgt;
    logic                        r_o_bad;
    logic                        r_o_fault;

    logic [DW-1:0] r_hi, r_lo;

    logic [DW-1:0]   rf_a, rf_b, rf_d;
    logic [DW-1:0]   op_a, op_b, op_d;
    logic [DW-1:0]   s2_val;
    logic [DW-1:0]   mem_q;
    ieu_pkg::t_rf_wr rf_wr;
    ieu_pkg::t_ex    ex;
    logic [AW-1:0]   mem_idx;
    logic [2*DW-1:0] prod;
    logic            rd_ok;

    // ------------------------------------------------------------------
    // Flow control: each stage advances when the one after it is empty or moving.
    // ------------------------------------------------------------------
    assign out_adv       = !r_ov || m_axis_tready;
    assign s2_move       = r2_v && out_adv;
    assign s1_move       = r1_v && (!r2_v || s2_move);
    assign s_axis_tready = !r1_v || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_base <= ieu_pkg::MEM_BASE_RESET;
        end else if (i_cfg_we) begin
            r_mem_base <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 capture; the register file reads at the same edge.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (s_axis_tready) begin
            r1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_func  <= s_axis_tdata[4:0];
            r1_rd    <= s_axis_tdata[9:5];
            r1_rs    <= s_axis_tdata[14:10];
            r1_rt    <= s_axis_tdata[19:15];
            r1_imm   <= s_axis_tdata[35:20];
            r1_shamt <= s_axis_tdata[40:36];
            r1_tgt   <= s_axis_tdata[72:41];
        end
    end

    ieu_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_ra    (s_axis_tdata[14:10]),
        .i_rb    (s_axis_tdata[19:15]),
        .i_rc    (s_axis_tdata[9:5]),
        .i_wr    (rf_wr),
        .o_qa    (rf_a),
        .o_qb    (rf_b),
        .o_qc    (rf_d)
    );

    // Operand select: register zero and indexes past the file read as zero;
    // a write still sitting in stage 2 overrides the file.
    always_comb begin
        op_a = '0;
        op_b = '0;
        op_d = '0;
        if (r1_rs != '0 && {1'b0, r1_rs} < NREGS) begin
            op_a = (r2_v && r2_wr && r2_rd == r1_rs) ? s2_val : rf_a;
        end
        if (r1_rt != '0 && {1'b0, r1_rt} < NREGS) begin
            op_b = (r2_v && r2_wr && r2_rd == r1_rt) ? s2_val : rf_b;
        end
        if (r1_rd != '0 && {1'b0, r1_rd} < NREGS) begin
            op_d = (r2_v && r2_wr && r2_rd == r1_rd) ? s2_val : rf_d;
        end
    end

    ieu_alu #(
        .MEM_WORDS (MEM_WORDS)
    ) u_alu (
        .i_func     (r1_func),
        .i_a        (op_a),
        .i_b        (op_b),
        .i_imm      (r1_imm),
        .i_shamt    (r1_shamt),
        .i_tgt      (r1_tgt),
        .i_mem_base (r_mem_base),
        .o_ex       (ex),
        .o_idx      (mem_idx),
        .o_prod     (prod)
    );

    // Loads read and stores write the data memory as the item leaves stage 1.
    ieu_dmem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_re    (s1_move && ex.ld && !ex.fault),
        .i_we    (s1_move && ex.st && !ex.fault),
        .i_addr  (mem_idx),
        .i_wdata (op_d),
        .o_rdata (mem_q)
    );

    // Update hi/lo as the mult leaves stage 1; an older mfhi/mflo in stage 2
    // leaves at the same edge and still sees the old pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (s1_move && ex.mul) begin
            r_hi <= prod[2*DW-1:DW];
            r_lo <= prod[DW-1:0];
        end
    end

    assign rd_ok = (r1_rd != '0) && ({1'b0, r1_rd} < NREGS);

    // ------------------------------------------------------------------
    // Stage 2.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (!r2_v || s2_move) begin
            r2_v <= s1_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r2_wr    <= ex.wr && rd_ok;
            r2_rd    <= r1_rd;
            r2_wsrc  <= ex.wsrc;
            r2_val   <= ex.val;
            r2_taken <= ex.taken;
            r2_tgt   <= r1_tgt;
            r2_bad   <= ex.bad;
            r2_fault <= ex.fault;
        end
    end

    always_comb begin
        case (r2_wsrc)
            ieu_pkg::WS_ALU: s2_val = r2_val;
            ieu_pkg::WS_MEM: s2_val = mem_q;
            ieu_pkg::WS_HI:  s2_val = r_hi;
            ieu_pkg::WS_LO:  s2_val = r_lo;
            default:         s2_val = r2_val;
        endcase
    end

    // Write back to the register file as the item leaves stage 2.
    always_comb begin
        rf_wr.en   = s2_move && r2_wr;
        rf_wr.addr = r2_rd;
        rf_wr.data = s2_val;
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_adv) begin
            r_ov <= s2_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_o_wr    <= r2_wr;
            r_o_rd    <= r2_wr ? r2_rd : '0;
            r_o_val   <= r2_wr ? s2_val : '0;
            r_o_taken <= r2_taken;
            r_o_tgt   <= r2_taken ? r2_tgt : '0;
            r_o_bad   <= r2_bad;
            r_o_fault <= r2_fault;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'b0, r_o_fault, r_o_bad, r_o_tgt, r_o_taken,
                            r_o_val, r_o_rd, r_o_wr};

endmodule

[design/ieu_regfile.sv]
// Register file: two synchronous banks with valid bits and same-edge write bypass.
`timescale 1ns / 1ps

module ieu_regfile #(
    parameter int NUM_REGS = ieu_pkg::NUM_REGS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_re,
    input  logic [ieu_pkg::REG_IDX_W-1:0] i_ra,
    input  logic [ieu_pkg::REG_IDX_W-1:0] i_rb,
    input  logic [ieu_pkg::REG_IDX_W-1:0] i_rc,
    input  ieu_pkg::t_rf_wr               i_wr,
    output logic [ieu_pkg::DATA_W-1:0]    o_qa,
    output logic [ieu_pkg::DATA_W-1:0]    o_qb,
    output logic [ieu_pkg::DATA_W-1:0]    o_qc
);

    localparam int RAW = $clog2(NUM_REGS);

    // Bank A serves ports a and c, bank B serves port b; both take every write.
    logic [ieu_pkg::DATA_W-1:0] r_bank_a [NUM_REGS];
    logic [ieu_pkg::DATA_W-1:0] r_bank_b [NUM_REGS];
    logic [NUM_REGS-1:0]        r_vld;

    logic [ieu_pkg::DATA_W-1:0] r_ma, r_mb, r_mc;
    logic                       r_va, r_vb, r_vc;
    logic                       r_ha, r_hb, r_hc;
    logic [ieu_pkg::DATA_W-1:0] r_wd;

    logic [RAW-1:0] ra, rb, rc, wa;

    assign ra = i_ra[RAW-1:0];
    assign rb = i_rb[RAW-1:0];
    assign rc = i_rc[RAW-1:0];
    assign wa = i_wr.addr[RAW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_bank_a[wa] <= i_wr.data;
            r_bank_b[wa] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_ma <= r_bank_a[ra];
            r_mc <= r_bank_a[rc];
            r_mb <= r_bank_b[rb];
            r_va <= r_vld[ra];
            r_vb <= r_vld[rb];
            r_vc <= r_vld[rc];
            r_ha <= i_wr.en && (wa == ra);
            r_hb <= i_wr.en && (wa == rb);
            r_hc <= i_wr.en && (wa == rc);
            r_wd <= i_wr.data;
        end
    end

    // Never-written entries read as zero.
    assign o_qa = r_ha ? r_wd : (r_va ? r_ma : '0);
    assign o_qb = r_hb ? r_wd : (r_vb ? r_mb : '0);
    assign o_qc = r_hc ? r_wd : (r_vc ? r_mc : '0);

endmodule

[design/ieu_dmem.sv]
// Word data memory with one read/write port and registered read data.
`timescale 1ns / 1ps

module ieu_dmem #(
    parameter int MEM_WORDS = ieu_pkg::MEM_WORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_re,
    input  logic                         i_we,
    input  logic [$clog2(MEM_WORDS)-1:0] i_addr,
    input  logic [ieu_pkg::DATA_W-1:0]   i_wdata,
    output logic [ieu_pkg::DATA_W-1:0]   o_rdata
);

    logic [ieu_pkg::DATA_W-1:0] r_mem [MEM_WORDS];
    logic [ieu_pkg::DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

[design/ieu_alu.sv]
// Decode and execute logic of the first stage: ALU, multiplier, branch and address.
`timescale 1ns / 1ps

module ieu_alu #(
    parameter int MEM_WORDS = ieu_pkg::MEM_WORDS_DEF
) (
    input  logic [ieu_pkg::FUNC_W-1:0]    i_func,
    input  logic [ieu_pkg::DATA_W-1:0]    i_a,
    input  logic [ieu_pkg::DATA_W-1:0]    i_b,
    input  logic [ieu_pkg::IMM_W-1:0]     i_imm,
    input  logic [ieu_pkg::SHAMT_W-1:0]   i_shamt,
    input  logic [ieu_pkg::DATA_W-1:0]    i_tgt,
    input  logic [ieu_pkg::BASE_W-1:0]    i_mem_base,
    output ieu_pkg::t_ex                  o_ex,
    output logic [$clog2(MEM_WORDS)-1:0]  o_idx,
    output logic [2*ieu_pkg::DATA_W-1:0]  o_prod
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int IW = ieu_pkg::IDX_W;

    logic signed [ieu_pkg::IMM_W:0]        imm_adj;
    logic signed [ieu_pkg::IMM_W:0]        imm_q;
    logic signed [IW-1:0]                  idx;
    logic                                  fault;
    logic [ieu_pkg::DATA_W-1:0]            imm_ext;
    logic signed [2*ieu_pkg::DATA_W-1:0]   prod;

    // Round the byte offset toward zero before the shift.
    assign imm_adj = $signed({i_imm[ieu_pkg::IMM_W-1], i_imm})
                   + (i_imm[ieu_pkg::IMM_W-1] ? 17'sd3 : 17'sd0);
    assign imm_q   = imm_adj >>> ieu_pkg::WORD_SHIFT;
    assign idx     = $signed({imm_q[ieu_pkg::IMM_W], imm_q})
                   + $signed({{(IW-ieu_pkg::BASE_W){1'b0}}, i_mem_base});
    assign fault   = idx[IW-1] || ({1'b0, idx[IW-2:0]} >= IW'(MEM_WORDS));
    assign o_idx   = idx[AW-1:0];

    assign imm_ext = {{(ieu_pkg::DATA_W-ieu_pkg::IMM_W){i_imm[ieu_pkg::IMM_W-1]}}, i_imm};
    assign prod    = $signed(i_a) * $signed(i_b);
    assign o_prod  = prod;

    always_comb begin
        o_ex       = '0;
        o_ex.wsrc  = ieu_pkg::WS_ALU;
        case (i_func)
            ieu_pkg::F_ADD: begin
                o_ex.wr  = 1'b1;
                o_ex.val = i_a + i_b;
            end
            ieu_pkg::F_ADDI: begin
                o_ex.wr  = 1'b1;
                o_ex.val = i_a + imm_ext;
            end
            ieu_pkg::F_SUB: begin
                o_ex.wr  = 1'b1;
                o_ex.val = i_a - i_b;
            end
            ieu_pkg::F_MULT: begin
                o_ex.mul = 1'b1;
            end
            ieu_pkg::F_MFHI: begin
                o_ex.wr   = 1'b1;
                o_ex.wsrc = ieu_pkg::WS_HI;
            end
            ieu_pkg::F_MFLO: begin
                o_ex.wr   = 1'b1;
                o_ex.wsrc = ieu_pkg::WS_LO;
            end
            ieu_pkg::F_AND: begin
                o_ex.wr  = 1'b1;
                o_ex.val = i_a & i_b;
            end
            ieu_pkg::F_OR: begin
                o_ex.wr  = 1'b1;
                o_ex.val = i_a | i_b;
            end
            ieu_pkg::F_NOR: begin
                o_ex.wr  = 1'b1;
                o_ex.val = ~(i_a | i_b);
            end
            ieu_pkg::F_SLL: begin
                o_ex.wr  = 1'b1;
                o_ex.val = i_a << i_shamt;
            end
            ieu_pkg::F_SRL: begin
                o_ex.wr  = 1'b1;
                o_ex.val = i_a >> i_shamt;
            end
            ieu_pkg::F_LW: begin
                o_ex.ld    = 1'b1;
                o_ex.fault = fault;
                o_ex.wr    = !fault;
                o_ex.wsrc  = ieu_pkg::WS_MEM;
            end
            ieu_pkg::F_SW: begin
                o_ex.st    = 1'b1;
                o_ex.fault = fault;
            end
            ieu_pkg::F_SLT: begin
                o_ex.wr  = 1'b1;
                o_ex.val = {{(ieu_pkg::DATA_W-1){1'b0}}, ($signed(i_a) < $signed(i_b))};
            end
            ieu_pkg::F_BNE: begin
                o_ex.taken = (i_a != i_b);
            end
            ieu_pkg::F_BEQ: begin
                o_ex.taken = (i_a == i_b);
            end
            ieu_pkg::F_J: begin
                o_ex.taken = (i_tgt != '0);
            end
            ieu_pkg::F_NOP: begin
                o_ex.wr = 1'b0;
            end
            default: begin
                o_ex.bad = 1'b1;
            end
        endcase
    end

endmodule
